// File: rtl/shs_pkg.sv
package shs_pkg;

   localparam int TIME_BITS_DEFAULT   = 32;
   localparam int STREAK_BITS_DEFAULT = 16;

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam logic        ENABLE_RESET         = 1'b1;
   localparam logic [31:0] CHECK_INTERVAL_RESET = 32'd60000;
   localparam logic [31:0] RECOVERY_INTERVAL_RESET = 32'd300000;
   localparam logic [31:0] STALE_LIMIT_RESET    = 32'd300000;
   localparam logic [15:0] FAILURE_LIMIT_RESET  = 16'd5;

   typedef enum logic [1:0] {
      OP_HEALTH_CHECK = 2'd0,
      OP_READ_OUTCOME = 2'd1,
      OP_RECOVERY     = 2'd2,
      OP_MANUAL_RESET = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_NONE       = 3'd0,
      ST_READ_OK    = 3'd1,
      ST_READ_FAIL  = 3'd2,
      ST_UNAVAIL    = 3'd3,
      ST_REQUEST    = 3'd4,
      ST_DELAYED    = 3'd5,
      ST_RECOVERED  = 3'd6,
      ST_REC_FAILED = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      CSR_ENABLE            = 3'd0,
      CSR_CHECK_INTERVAL    = 3'd1,
      CSR_RECOVERY_INTERVAL = 3'd2,
      CSR_STALE_LIMIT       = 3'd3,
      CSR_FAILURE_LIMIT     = 3'd4
   } csr_index_type;

   typedef struct packed {
      status_type  status;
      logic        sensor_healthy;
      logic        sensor_ready;
      logic [15:0] fail_streak;
      logic [31:0] success_count;
      logic [31:0] failure_count;
      logic [31:0] delayed_count;
   } rsp_type;

endpackage

// File: rtl/sensor_health_supervisor_core.sv
// Sensor health supervisor core.
// Request channel (req_*): one event per request, valid/ready. The operation
// selects a health check, a read outcome, a recovery outcome or a manual
// reset; each carries the current millisecond timestamp.
// Response channel (rsp_*): exactly one response per request, in order,
// giving the status code and the sensor flags and counters after the event.
// A request accepted while the response register is free or being emptied is
// written into it at the accepting edge. One request per cycle is taken while
// req_ready is high; all the work is a single pass of compares and counter
// updates against the state registers, which update at the accepting edge.
// A two-entry output stage (response register plus skid register) keeps
// req_ready high while one response waits; req_ready drops only when both
// entries hold data, i.e. after a request is accepted at an edge where the
// receiver stalls a waiting response.
// Reset (synchronous, active high): flags, streak, timestamps and counters
// clear to zero, configuration registers return to defaults, output stage
// empties. Configuration goes through the csr_* APB port at byte addresses
// 4*i; pready is always high. Write configuration only while idle.
module sensor_health_supervisor_core #(
   parameter int TIME_BITS   = shs_pkg::TIME_BITS_DEFAULT,
   parameter int STREAK_BITS = shs_pkg::STREAK_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_operation,
   input  logic [31:0]                        req_now_ms,
   input  logic                               req_read_ok,
   input  logic                               req_recovery_ok,
   input  logic                               req_maintenance_safe,

   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [2:0]                         rsp_status,
   output logic                               rsp_sensor_healthy,
   output logic                               rsp_sensor_ready,
   output logic [15:0]                        rsp_fail_streak,
   output logic [31:0]                        rsp_success_count,
   output logic [31:0]                        rsp_failure_count,
   output logic [31:0]                        rsp_delayed_count,

   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [shs_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [shs_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [shs_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);

   localparam int CMP_BITS = (TIME_BITS > 32) ? TIME_BITS : 32;
   localparam int SL_BITS  = (STREAK_BITS > 16) ? STREAK_BITS : 16;
   localparam logic [STREAK_BITS-1:0] STREAK_MAX = {STREAK_BITS{1'b1}};

   // configuration
   logic        enable_ff;
   logic [31:0] check_interval_ff;
   logic [31:0] recovery_interval_ff;
   logic [31:0] stale_limit_ff;
   logic [15:0] failure_limit_ff;

   logic                   csr_write;
   shs_pkg::csr_index_type csr_index;

   // supervisor state
   logic                   ready_flag_ff,   ready_flag_in;
   logic                   healthy_flag_ff, healthy_flag_in;
   logic [STREAK_BITS-1:0] streak_ff,       streak_in;
   logic [TIME_BITS-1:0]   last_success_ff, last_success_in;
   logic [TIME_BITS-1:0]   last_recovery_ff, last_recovery_in;
   logic [TIME_BITS-1:0]   last_check_ff,   last_check_in;
   logic [31:0]            good_total_ff,   good_total_in;
   logic [31:0]            bad_total_ff,    bad_total_in;
   logic [31:0]            postponed_ff,    postponed_in;

   // output stage
   logic             main_valid_ff, main_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   shs_pkg::rsp_type main_ff, main_in;
   shs_pkg::rsp_type skid_ff, skid_in;
   shs_pkg::rsp_type result;
   shs_pkg::status_type status;

   logic                   req_fire;
   logic                   rsp_fire;
   logic [TIME_BITS-1:0]   now_t;
   logic                   check_due;
   logic                   recovery_due;
   logic                   stale;
   logic [STREAK_BITS-1:0] streak_inc;
   logic                   inc_at_limit;
   logic                   streak_at_limit;
   logic [STREAK_BITS-1:0] limit_sat;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = shs_pkg::csr_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff            <= shs_pkg::ENABLE_RESET;
         check_interval_ff    <= shs_pkg::CHECK_INTERVAL_RESET;
         recovery_interval_ff <= shs_pkg::RECOVERY_INTERVAL_RESET;
         stale_limit_ff       <= shs_pkg::STALE_LIMIT_RESET;
         failure_limit_ff     <= shs_pkg::FAILURE_LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            shs_pkg::CSR_ENABLE:            enable_ff            <= csr_pwdata[0];
            shs_pkg::CSR_CHECK_INTERVAL:    check_interval_ff    <= csr_pwdata;
            shs_pkg::CSR_RECOVERY_INTERVAL: recovery_interval_ff <= csr_pwdata;
            shs_pkg::CSR_STALE_LIMIT:       stale_limit_ff       <= csr_pwdata;
            shs_pkg::CSR_FAILURE_LIMIT:     failure_limit_ff     <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         shs_pkg::CSR_ENABLE:            csr_prdata = {31'd0, enable_ff};
         shs_pkg::CSR_CHECK_INTERVAL:    csr_prdata = check_interval_ff;
         shs_pkg::CSR_RECOVERY_INTERVAL: csr_prdata = recovery_interval_ff;
         shs_pkg::CSR_STALE_LIMIT:       csr_prdata = stale_limit_ff;
         shs_pkg::CSR_FAILURE_LIMIT:     csr_prdata = {16'd0, failure_limit_ff};
         default:                        csr_prdata = '0;
      endcase
   end

   assign req_ready = ~skid_valid_ff;
   assign req_fire  = req_valid & req_ready;
   assign rsp_fire  = main_valid_ff & rsp_ready;

   // elapsed times wrap at TIME_BITS
   assign now_t        = TIME_BITS'(req_now_ms);
   assign check_due    = CMP_BITS'(TIME_BITS'(now_t - last_check_ff))
                         >= CMP_BITS'(check_interval_ff);
   assign recovery_due = CMP_BITS'(TIME_BITS'(now_t - last_recovery_ff))
                         > CMP_BITS'(recovery_interval_ff);
   assign stale        = CMP_BITS'(TIME_BITS'(now_t - last_success_ff))
                         > CMP_BITS'(stale_limit_ff);

   assign streak_inc      = (streak_ff == STREAK_MAX) ? streak_ff : streak_ff + 1'b1;
   assign inc_at_limit    = SL_BITS'(streak_inc) >= SL_BITS'(failure_limit_ff);
   assign streak_at_limit = SL_BITS'(streak_ff)  >= SL_BITS'(failure_limit_ff);
   assign limit_sat       = (SL_BITS'(failure_limit_ff) < SL_BITS'(STREAK_MAX))
                            ? STREAK_BITS'(failure_limit_ff) : STREAK_MAX;

   always_comb begin
      logic want;
      want             = 1'b0;
      status           = shs_pkg::ST_NONE;
      ready_flag_in    = ready_flag_ff;
      healthy_flag_in  = healthy_flag_ff;
      streak_in        = streak_ff;
      last_success_in  = last_success_ff;
      last_recovery_in = last_recovery_ff;
      last_check_in    = last_check_ff;
      good_total_in    = good_total_ff;
      bad_total_in     = bad_total_ff;
      postponed_in     = postponed_ff;
      case (shs_pkg::op_type'(req_operation))
         shs_pkg::OP_HEALTH_CHECK: begin
            if (enable_ff && check_due) begin
               last_check_in = now_t;
               if (!ready_flag_ff) begin
                  want = recovery_due;
               end else if (!healthy_flag_ff) begin
                  want = streak_at_limit && recovery_due;
               end else if (stale) begin
                  healthy_flag_in = 1'b0;
                  want            = 1'b1;
               end
               if (want) begin
                  if (req_maintenance_safe) begin
                     ready_flag_in   = 1'b0;
                     healthy_flag_in = 1'b0;
                     status          = shs_pkg::ST_REQUEST;
                  end else begin
                     postponed_in = postponed_ff + 32'd1;
                     status       = shs_pkg::ST_DELAYED;
                  end
               end
            end
         end
         shs_pkg::OP_READ_OUTCOME: begin
            if (!healthy_flag_ff || !ready_flag_ff) begin
               status = shs_pkg::ST_UNAVAIL;
            end else if (req_read_ok) begin
               good_total_in   = good_total_ff + 32'd1;
               streak_in       = '0;
               last_success_in = now_t;
               status          = shs_pkg::ST_READ_OK;
            end else begin
               bad_total_in = bad_total_ff + 32'd1;
               streak_in    = streak_inc;
               if (inc_at_limit) begin
                  healthy_flag_in = 1'b0;
               end
               status = shs_pkg::ST_READ_FAIL;
            end
         end
         shs_pkg::OP_RECOVERY: begin
            last_recovery_in = now_t;
            if (req_recovery_ok) begin
               ready_flag_in   = 1'b1;
               healthy_flag_in = 1'b1;
               streak_in       = '0;
               last_success_in = now_t;
               status          = shs_pkg::ST_RECOVERED;
            end else begin
               ready_flag_in   = 1'b0;
               healthy_flag_in = 1'b0;
               status          = shs_pkg::ST_REC_FAILED;
            end
         end
         default: begin
            streak_in       = limit_sat;
            healthy_flag_in = 1'b0;
            if (req_maintenance_safe) begin
               ready_flag_in = 1'b0;
               status        = shs_pkg::ST_REQUEST;
            end else begin
               status = shs_pkg::ST_DELAYED;
            end
         end
      endcase
   end

   always_comb begin
      result.status         = status;
      result.sensor_healthy = healthy_flag_in;
      result.sensor_ready   = ready_flag_in;
      result.fail_streak    = 16'(streak_in);
      result.success_count  = good_total_in;
      result.failure_count  = bad_total_in;
      result.delayed_count  = postponed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_flag_ff    <= 1'b0;
         healthy_flag_ff  <= 1'b0;
         streak_ff        <= '0;
         last_success_ff  <= '0;
         last_recovery_ff <= '0;
         last_check_ff    <= '0;
         good_total_ff    <= '0;
         bad_total_ff     <= '0;
         postponed_ff     <= '0;
      end else if (req_fire) begin
         ready_flag_ff    <= ready_flag_in;
         healthy_flag_ff  <= healthy_flag_in;
         streak_ff        <= streak_in;
         last_success_ff  <= last_success_in;
         last_recovery_ff <= last_recovery_in;
         last_check_ff    <= last_check_in;
         good_total_ff    <= good_total_in;
         bad_total_ff     <= bad_total_in;
         postponed_ff     <= postponed_in;
      end
   end

   // response register plus skid register
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (rsp_fire || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = req_fire;
            main_in       = result;
         end
      end else if (req_fire) begin
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid          = main_valid_ff;
   assign rsp_status         = main_ff.status;
   assign rsp_sensor_healthy = main_ff.sensor_healthy;
   assign rsp_sensor_ready   = main_ff.sensor_ready;
   assign rsp_fail_streak    = main_ff.fail_streak;
   assign rsp_success_count  = main_ff.success_count;
   assign rsp_failure_count  = main_ff.failure_count;
   assign rsp_delayed_count  = main_ff.delayed_count;

endmodule

// File: rtl/shs_checker.sv
module shs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [2:0]                        rsp_status,
   input logic                              rsp_sensor_healthy,
   input logic                              rsp_sensor_ready,
   input logic [15:0]                       rsp_fail_streak,
   input logic [31:0]                       rsp_success_count,
   input logic [31:0]                       rsp_failure_count,
   input logic [31:0]                       rsp_delayed_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_success_count) && $stable(rsp_fail_streak))
      else $error("response changed while stalled");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> rsp_valid)
      else $error("request did not reach an empty response register");

   a_read_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == shs_pkg::ST_READ_OK
         |-> rsp_sensor_healthy && rsp_sensor_ready && rsp_fail_streak == 16'd0)
      else $error("good read without healthy, ready sensor and clear streak");

   a_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == shs_pkg::ST_REQUEST
         |-> !rsp_sensor_healthy && !rsp_sensor_ready)
      else $error("recover request left sensor flags set");

   a_recovered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == shs_pkg::ST_RECOVERED
         |-> rsp_sensor_healthy && rsp_sensor_ready && rsp_fail_streak == 16'd0)
      else $error("recovery did not restore the sensor");

endmodule

bind sensor_health_supervisor_core shs_checker u_shs_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_status         (rsp_status),
   .rsp_sensor_healthy (rsp_sensor_healthy),
   .rsp_sensor_ready   (rsp_sensor_ready),
   .rsp_fail_streak    (rsp_fail_streak),
   .rsp_success_count  (rsp_success_count),
   .rsp_failure_count  (rsp_failure_count),
   .rsp_delayed_count  (rsp_delayed_count)
);

// File: verif/sensor_health_supervisor_core_test.sv
module sensor_health_supervisor_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT   = 5000;
   localparam int HOLD_CYCLES   = 60;
   localparam int PHASE_EVENTS  = 100;
   localparam int NUM_PHASES    = 8;
   localparam int DIRECTED_ROWS = 24;

   typedef struct {
      shs_pkg::op_type  op;
      logic [31:0]      stamp;
      logic             rd_ok;
      logic             rec_ok;
      logic             safe;
      logic             pinned;
      shs_pkg::rsp_type want;
   } event_row_type;

   typedef struct {
      logic        enable;
      logic [31:0] check_ms;
      logic [31:0] recover_ms;
      logic [31:0] stale_ms;
      logic [15:0] limit;
      int unsigned step_max;
   } phase_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = shs_pkg::OP_HEALTH_CHECK;
   logic [31:0] req_now_ms = '0;
   logic        req_read_ok = 1'b0;
   logic        req_recovery_ok = 1'b0;
   logic        req_maintenance_safe = 1'b0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic        rsp_sensor_healthy;
   logic        rsp_sensor_ready;
   logic [15:0] rsp_fail_streak;
   logic [31:0] rsp_success_count;
   logic [31:0] rsp_failure_count;
   logic [31:0] rsp_delayed_count;

   logic                              csr_psel = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite = 1'b0;
   logic [shs_pkg::CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [shs_pkg::CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [shs_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                              csr_pready;

   sensor_health_supervisor_core dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // supervisor state as predicted
   logic        cfg_enable;
   logic [31:0] cfg_check_ms;
   logic [31:0] cfg_recover_ms;
   logic [31:0] cfg_stale_ms;
   logic [15:0] cfg_limit;
   logic        st_ready;
   logic        st_healthy;
   logic [15:0] st_streak;
   logic [31:0] st_last_good;
   logic [31:0] st_last_recover;
   logic [31:0] st_last_check;
   logic [31:0] n_good;
   logic [31:0] n_bad;
   logic [31:0] n_postponed;

   shs_pkg::rsp_type pending_reports[$];
   shs_pkg::rsp_type predicted;
   shs_pkg::rsp_type observed;
   logic             pin_valid = 1'b0;
   shs_pkg::rsp_type pin_value = '0;
   int               mismatch_count = 0;
   int               quiet_cycles = 0;
   int unsigned      send_idle_pct = 0;
   int unsigned      stall_pct = 0;
   logic             hold_request = 1'b0;
   logic [31:0]      cur_ms = '0;

   event_row_type directed_rows [DIRECTED_ROWS] = '{
      '{shs_pkg::OP_READ_OUTCOME, 32'd0,      1'b1, 1'b0, 1'b0, 1'b1,
        '{shs_pkg::ST_UNAVAIL, 1'b0, 1'b0, 16'd0, 32'd0, 32'd0, 32'd0}},
      '{shs_pkg::OP_HEALTH_CHECK, 32'd100,    1'b0, 1'b1, 1'b1, 1'b1,
        '{shs_pkg::ST_NONE, 1'b0, 1'b0, 16'd0, 32'd0, 32'd0, 32'd0}},
      '{shs_pkg::OP_HEALTH_CHECK, 32'd300001, 1'b1, 1'b1, 1'b0, 1'b1,
        '{shs_pkg::ST_DELAYED, 1'b0, 1'b0, 16'd0, 32'd0, 32'd0, 32'd1}},
      '{shs_pkg::OP_HEALTH_CHECK, 32'd360001, 1'b0, 1'b0, 1'b1, 1'b1,
        '{shs_pkg::ST_REQUEST, 1'b0, 1'b0, 16'd0, 32'd0, 32'd0, 32'd1}},
      '{shs_pkg::OP_RECOVERY,     32'd360010, 1'b0, 1'b1, 1'b0, 1'b1,
        '{shs_pkg::ST_RECOVERED, 1'b1, 1'b1, 16'd0, 32'd0, 32'd0, 32'd1}},
      '{shs_pkg::OP_READ_OUTCOME, 32'd360020, 1'b1, 1'b0, 1'b1, 1'b1,
        '{shs_pkg::ST_READ_OK, 1'b1, 1'b1, 16'd0, 32'd1, 32'd0, 32'd1}},
      '{shs_pkg::OP_READ_OUTCOME, 32'd360030, 1'b0, 1'b1, 1'b0, 1'b0, '0},
      '{shs_pkg::OP_READ_OUTCOME, 32'd360040, 1'b0, 1'b0, 1'b1, 1'b0, '0},
      '{shs_pkg::OP_READ_OUTCOME, 32'd360050, 1'b0, 1'b1, 1'b1, 1'b0, '0},
      '{shs_pkg::OP_READ_OUTCOME, 32'd360060, 1'b0, 1'b0, 1'b0, 1'b0, '0},
      '{shs_pkg::OP_READ_OUTCOME, 32'd360070, 1'b0, 1'b1, 1'b0, 1'b0, '0},
      '{shs_pkg::OP_READ_OUTCOME, 32'd360080, 1'b1, 1'b0, 1'b0, 1'b0, '0},
      '{shs_pkg::OP_HEALTH_CHECK, 32'd420001, 1'b1, 1'b0, 1'b1, 1'b0, '0},
      '{shs_pkg::OP_HEALTH_CHECK, 32'd700000, 1'b0, 1'b1, 1'b1, 1'b0, '0},
      '{shs_pkg::OP_RECOVERY,     32'd700010, 1'b1, 1'b0, 1'b1, 1'b0, '0},
      '{shs_pkg::OP_RECOVERY,     32'hFFFF_FF00, 1'b0, 1'b1, 1'b0, 1'b0, '0},
      '{shs_pkg::OP_READ_OUTCOME, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b0, '0},
      '{shs_pkg::OP_HEALTH_CHECK, 32'h0003_0000, 1'b0, 1'b0, 1'b1, 1'b0, '0},
      '{shs_pkg::OP_HEALTH_CHECK, 32'h0005_0000, 1'b1, 1'b1, 1'b0, 1'b0, '0},
      '{shs_pkg::OP_MANUAL_RESET, 32'h0005_0010, 1'b1, 1'b0, 1'b0, 1'b0, '0},
      '{shs_pkg::OP_MANUAL_RESET, 32'h0005_0020, 1'b0, 1'b1, 1'b1, 1'b0, '0},
      '{shs_pkg::OP_READ_OUTCOME, 32'h0005_0030, 1'b0, 1'b0, 1'b0, 1'b0, '0},
      '{shs_pkg::OP_RECOVERY,     32'h0000_0000, 1'b1, 1'b1, 1'b1, 1'b0, '0},
      '{shs_pkg::OP_READ_OUTCOME, 32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b0, '0}
   };

   phase_row_type phases [NUM_PHASES] = '{
      '{1'b1, 32'd60000, 32'd300000, 32'd300000, 16'd5, 40000},
      '{1'b1, 32'd0, 32'd0, 32'd0, 16'd1, 4},
      '{1'b1, 32'd50, 32'd200, 32'd300, 16'd3, 60},
      '{1'b1, 32'd10, 32'd100, 32'd150, 16'd0, 40},
      '{1'b0, 32'd20, 32'd80, 32'd100, 16'd2, 40},
      '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF},
      '{1'b1, 32'd1000, 32'd5000, 32'd4000, 16'd2, 1500},
      '{1'b1, 32'd30, 32'd60, 32'd100, 16'hFFFF, 50}
   };

   function automatic shs_pkg::rsp_type supervise_event(shs_pkg::op_type op,
                                                        logic [31:0] stamp,
                                                        logic rd_ok, logic rec_ok,
                                                        logic safe);
      shs_pkg::rsp_type r;
      logic [31:0]      since_check;
      logic [31:0]      since_recover;
      logic [31:0]      since_good;
      logic             wants;
      since_check   = stamp - st_last_check;
      since_recover = stamp - st_last_recover;
      since_good    = stamp - st_last_good;
      wants         = 1'b0;
      r             = '0;
      r.status      = shs_pkg::ST_NONE;
      case (op)
         shs_pkg::OP_HEALTH_CHECK: begin
            if (cfg_enable && since_check >= cfg_check_ms) begin
               st_last_check = stamp;
               if (!st_ready) begin
                  wants = since_recover > cfg_recover_ms;
               end else if (!st_healthy) begin
                  wants = st_streak >= cfg_limit && since_recover > cfg_recover_ms;
               end else if (since_good > cfg_stale_ms) begin
                  st_healthy = 1'b0;
                  wants = 1'b1;
               end
               if (wants && safe) begin
                  st_ready   = 1'b0;
                  st_healthy = 1'b0;
                  r.status   = shs_pkg::ST_REQUEST;
               end else if (wants) begin
                  n_postponed = n_postponed + 32'd1;
                  r.status    = shs_pkg::ST_DELAYED;
               end
            end
         end
         shs_pkg::OP_READ_OUTCOME: begin
            if (!st_ready || !st_healthy) begin
               r.status = shs_pkg::ST_UNAVAIL;
            end else if (rd_ok) begin
               n_good       = n_good + 32'd1;
               st_streak    = '0;
               st_last_good = stamp;
               r.status     = shs_pkg::ST_READ_OK;
            end else begin
               n_bad = n_bad + 32'd1;
               if (st_streak != 16'hFFFF) st_streak = st_streak + 16'd1;
               if (st_streak >= cfg_limit) st_healthy = 1'b0;
               r.status = shs_pkg::ST_READ_FAIL;
            end
         end
         shs_pkg::OP_RECOVERY: begin
            st_last_recover = stamp;
            st_ready   = rec_ok;
            st_healthy = rec_ok;
            if (rec_ok) begin
               st_streak    = '0;
               st_last_good = stamp;
               r.status     = shs_pkg::ST_RECOVERED;
            end else begin
               r.status = shs_pkg::ST_REC_FAILED;
            end
         end
         default: begin
            st_streak  = cfg_limit;
            st_healthy = 1'b0;
            if (safe) begin
               st_ready = 1'b0;
               r.status = shs_pkg::ST_REQUEST;
            end else begin
               r.status = shs_pkg::ST_DELAYED;
            end
         end
      endcase
      r.sensor_healthy = st_healthy;
      r.sensor_ready   = st_ready;
      r.fail_streak    = st_streak;
      r.success_count  = n_good;
      r.failure_count  = n_bad;
      r.delayed_count  = n_postponed;
      return r;
   endfunction

   task automatic flag_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) flag_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   task automatic compare_report(shs_pkg::rsp_type got, shs_pkg::rsp_type want);
      check_field("status", got.status, want.status);
      check_field("sensor_healthy", got.sensor_healthy, want.sensor_healthy);
      check_field("sensor_ready", got.sensor_ready, want.sensor_ready);
      check_field("fail_streak", got.fail_streak, want.fail_streak);
      check_field("success_count", got.success_count, want.success_count);
      check_field("failure_count", got.failure_count, want.failure_count);
      check_field("delayed_count", got.delayed_count, want.delayed_count);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            predicted = supervise_event(shs_pkg::op_type'(req_operation), req_now_ms,
                                        req_read_ok, req_recovery_ok,
                                        req_maintenance_safe);
            pending_reports.push_back(pin_valid ? pin_value : predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_reports.size() == 0) begin
               flag_mismatch("response with no request pending");
            end else begin
               observed.status         = shs_pkg::status_type'(rsp_status);
               observed.sensor_healthy = rsp_sensor_healthy;
               observed.sensor_ready   = rsp_sensor_ready;
               observed.fail_streak    = rsp_fail_streak;
               observed.success_count  = rsp_success_count;
               observed.failure_count  = rsp_failure_count;
               observed.delayed_count  = rsp_delayed_count;
               compare_report(observed, pending_reports.pop_front());
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("[sensor_health_supervisor_core] ERROR");
               $finish;
            end
         end
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic offer_event(shs_pkg::op_type op, logic [31:0] stamp, logic rd_ok,
                              logic rec_ok, logic safe, logic pinned,
                              shs_pkg::rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_operation        <= op;
      req_now_ms           <= stamp;
      req_read_ok          <= rd_ok;
      req_recovery_ok      <= rec_ok;
      req_maintenance_safe <= safe;
      pin_valid            <= pinned;
      pin_value            <= want;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_reports();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_reports.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(shs_pkg::csr_index_type idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         shs_pkg::CSR_ENABLE:            cfg_enable     = value[0];
         shs_pkg::CSR_CHECK_INTERVAL:    cfg_check_ms   = value;
         shs_pkg::CSR_RECOVERY_INTERVAL: cfg_recover_ms = value;
         shs_pkg::CSR_STALE_LIMIT:       cfg_stale_ms   = value;
         default:                        cfg_limit      = value[15:0];
      endcase
   endtask

   task automatic random_event(int unsigned step_max);
      int unsigned pick;
      logic [31:0] stamp;
      pick   = $urandom_range(99);
      cur_ms = cur_ms + $urandom_range(step_max);
      stamp  = cur_ms;
      if (pick < 5) begin
         offer_event(shs_pkg::op_type'($urandom_range(3)), $urandom,
                     1'($urandom_range(1)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), 1'b0, '0);
      end else if (pick < 35) begin
         offer_event(shs_pkg::OP_HEALTH_CHECK, stamp, 1'($urandom_range(1)),
                     1'($urandom_range(1)), $urandom_range(9) < 7, 1'b0, '0);
      end else if (pick < 80) begin
         offer_event(shs_pkg::OP_READ_OUTCOME, stamp, $urandom_range(9) < 8,
                     1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, '0);
      end else if (pick < 93) begin
         offer_event(shs_pkg::OP_RECOVERY, stamp, 1'($urandom_range(1)),
                     $urandom_range(3) != 0, 1'($urandom_range(1)), 1'b0, '0);
      end else begin
         offer_event(shs_pkg::OP_MANUAL_RESET, stamp, 1'($urandom_range(1)),
                     1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, '0);
      end
   endtask

   initial begin
      cfg_enable      = shs_pkg::ENABLE_RESET;
      cfg_check_ms    = shs_pkg::CHECK_INTERVAL_RESET;
      cfg_recover_ms  = shs_pkg::RECOVERY_INTERVAL_RESET;
      cfg_stale_ms    = shs_pkg::STALE_LIMIT_RESET;
      cfg_limit       = shs_pkg::FAILURE_LIMIT_RESET;
      st_ready        = 1'b0;
      st_healthy      = 1'b0;
      st_streak       = '0;
      st_last_good    = '0;
      st_last_recover = '0;
      st_last_check   = '0;
      n_good          = '0;
      n_bad           = '0;
      n_postponed     = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         offer_event(directed_rows[i].op, directed_rows[i].stamp, directed_rows[i].rd_ok,
                     directed_rows[i].rec_ok, directed_rows[i].safe,
                     directed_rows[i].pinned, directed_rows[i].want);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_reports();
         csr_write(shs_pkg::CSR_ENABLE, {31'd0, phases[p].enable});
         csr_write(shs_pkg::CSR_CHECK_INTERVAL, phases[p].check_ms);
         csr_write(shs_pkg::CSR_RECOVERY_INTERVAL, phases[p].recover_ms);
         csr_write(shs_pkg::CSR_STALE_LIMIT, phases[p].stale_ms);
         csr_write(shs_pkg::CSR_FAILURE_LIMIT, {16'd0, phases[p].limit});
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 65; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 65; end
            default: begin send_idle_pct = 6; stall_pct = 6; end
         endcase
         for (int i = 0; i < PHASE_EVENTS; i++) begin
            // long receiver hold-off while requests keep coming
            if (p == 2 && i == PHASE_EVENTS / 2) hold_request = 1'b1;
            random_event(phases[p].step_max);
         end
      end

      drain_reports();
      repeat (10) @(posedge clock);
      if (pending_reports.size() != 0)
         flag_mismatch($sformatf("%0d responses never arrived", pending_reports.size()));
      if (mismatch_count == 0) begin
         $display("[sensor_health_supervisor_core] OK");
      end else begin
         $display("[sensor_health_supervisor_core] ERROR");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/shs_pkg.sv
rtl/sensor_health_supervisor_core.sv
rtl/shs_checker.sv
verif/sensor_health_supervisor_core_test.sv
